// File: hw/rtl/pidpc_pkg.sv
// ----------------------------------------------------------------------------
// pidpc_pkg
// Shared constants, types and helpers for the PID position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidpc_pkg;

   // Sample and drive scaling
   localparam int ADC_BITS    = 12;
   localparam int CAL_W       = 12;
   localparam int DUTY_FULL   = 120;

   // Control law constants
   localparam int DEG_FULL    = 360;
   localparam int ANGLE_MAX   = 1023;
   localparam int SP_LOW      = 10;
   localparam int SP_HIGH     = 350;
   localparam int DEADBAND    = 2;
   localparam int GAIN_SCALE  = 100;
   localparam int STEP_LIMIT  = 100;
   localparam int INTEG_LIMIT = 800;
   localparam int SIGN_HYST   = 10;
   localparam int DUTY_MIN    = 40;
   localparam int SUPPLY_MV   = 5000;

   // Shared divider sizes
   localparam int DVD_W       = 23;
   localparam int DVS_W       = 13;
   localparam int DIV_CNT_W   = $clog2(DVD_W);

   // Constant divisions as reciprocal multiplication, exact for the operand ranges
   localparam int GAIN_SHIFT  = 28;
   localparam int GAIN_RECIP  = (2**GAIN_SHIFT + GAIN_SCALE - 1) / GAIN_SCALE;
   localparam int MV_SHIFT    = 27;
   localparam int MV_RECIP    = (2**MV_SHIFT + DUTY_FULL - 1) / DUTY_FULL;

   // Register map indexes
   localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
   localparam logic [2:0] REG_SP_CAL_ZERO = 3'd3;
   localparam logic [2:0] REG_SP_CAL_FULL = 3'd4;
   localparam logic [2:0] REG_FB_CAL_ZERO = 3'd5;
   localparam logic [2:0] REG_FB_CAL_FULL = 3'd6;

   // Direction codes
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_POS  = 2'd1;
   localparam logic [1:0] DIR_NEG  = 2'd2;

   typedef struct packed {
      logic [7:0]       prop_gain;
      logic [6:0]       integ_gain;
      logic [6:0]       deriv_gain;
      logic [CAL_W-1:0] sp_cal_zero;
      logic [CAL_W-1:0] sp_cal_full;
      logic [CAL_W-1:0] fb_cal_zero;
      logic [CAL_W-1:0] fb_cal_full;
   } pidpc_cfg_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] feedback_raw;
      logic [ADC_BITS-1:0] setpoint_raw;
   } pidpc_item_type;

   typedef struct packed {
      logic [12:0]        drive_mv;
      logic signed [7:0]  control_out;
      logic signed [11:0] angle_error;
      logic signed [10:0] feedback_deg;
      logic [8:0]         setpoint_deg;
      logic [1:0]         dir_write;
      logic [6:0]         duty;
   } pidpc_result_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SP, S_SP_WAIT, S_FB, S_FB_WAIT, S_ERR, S_MUL_I, S_MUL_D,
      S_QUO, S_QUO_WAIT, S_CTRL, S_MV_WAIT, S_OUT
   } pidpc_state_type;

   // Apply sign to a quotient magnitude and saturate to the angle range
   function automatic logic signed [10:0] sat_angle(input logic [DVD_W-1:0] q,
                                                    input logic neg);
      logic signed [10:0] r;
      if (!neg) begin
         r = (q > DVD_W'(ANGLE_MAX)) ? 11'sd1023 : $signed(q[10:0]);
      end else begin
         r = (q > DVD_W'(ANGLE_MAX + 1)) ? -11'sd1024 : $signed(-q[10:0]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pidpc_front.sv
// ----------------------------------------------------------------------------
// pidpc_front
// Input side: accepts sample pairs and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpc_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  pidpc_pkg::pidpc_item_type in_item,
   output logic                     q_valid,
   input  wire                      q_pop,
   output pidpc_pkg::pidpc_item_type q_item
);
   import pidpc_pkg::*;

   pidpc_item_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;

   // Take an item whenever a slot is free
   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pidpc_div.sv
// ----------------------------------------------------------------------------
// pidpc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpc_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [pidpc_pkg::DVD_W-1:0]   dividend,
   input  wire [pidpc_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [pidpc_pkg::DVD_W-1:0]  quotient
);
   import pidpc_pkg::*;

   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       shifted;
   logic [DVS_W:0]       diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Shift in one dividend bit, subtract when it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/pidpc_back.sv
// ----------------------------------------------------------------------------
// pidpc_back
// Control sequencer: angle mapping, PID sum, limits, direction handling.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpc_back (
   input  wire                          clock,
   input  wire                          reset,
   input  pidpc_pkg::pidpc_cfg_type     cfg,
   input  wire                          q_valid,
   output logic                         q_pop,
   input  pidpc_pkg::pidpc_item_type    q_item,
   output logic                         out_valid,
   input  wire                          out_ready,
   output pidpc_pkg::pidpc_result_type  out_item
);
   import pidpc_pkg::*;

   pidpc_state_type    state_ff, state_in;
   pidpc_item_type     raw_ff, raw_in;
   logic               neg_ff, neg_in;
   logic signed [21:0] acc_ff, acc_in;
   logic signed [11:0] deriv_ff, deriv_in;
   logic signed [7:0]  ctl_ff, ctl_in;
   logic [7:0]         mag_ff, mag_in;
   logic [13:0]        quo_ff, quo_in;
   pidpc_result_type   res_ff, res_in;

   // Controller state
   logic signed [10:0] integ_ff, integ_in;
   logic signed [10:0] last_fb_ff, last_fb_in;
   logic signed [7:0]  last_out_ff, last_out_in;
   logic [1:0]         last_dir_ff, last_dir_in;
   logic               rev_pend_ff, rev_pend_in;
   logic               pend_fwd_ff, pend_fwd_in;

   // Divider port
   logic               div_start;
   logic [DVD_W-1:0]   div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   logic               div_done;
   logic [DVD_W-1:0]   div_q;

   // Scratch
   logic [CAL_W-1:0]   cal_zero, cal_full;
   logic [ADC_BITS-1:0] raw_sel;
   logic signed [12:0] span, diff;
   logic signed [21:0] num, num_mag;
   logic signed [12:0] span_mag;
   logic signed [10:0] deg;
   logic signed [11:0] err;
   logic [21:0]        acc_mag;
   logic [43:0]        quo_prod;
   logic signed [14:0] ctl_q;
   logic signed [15:0] lim, step;
   logic signed [12:0] integ_sum;
   logic [1:0]         sign;
   logic               wind_hold;
   logic [7:0]         mag;
   logic [19:0]        mv_num;
   logic [40:0]        mv_prod;

   pidpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign out_valid = (state_ff == S_OUT);
   assign out_item  = res_ff;

   // Next state, datapath and outputs
   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      deriv_in     = deriv_ff;
      ctl_in       = ctl_ff;
      mag_in       = mag_ff;
      quo_in       = quo_ff;
      res_in       = res_ff;
      integ_in     = integ_ff;
      last_fb_in   = last_fb_ff;
      last_out_in  = last_out_ff;
      last_dir_in  = last_dir_ff;
      rev_pend_in  = rev_pend_ff;
      pend_fwd_in  = pend_fwd_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      // Angle mapping operands for the current input
      if (state_ff == S_SP) begin
         cal_zero = cfg.sp_cal_zero;
         cal_full = cfg.sp_cal_full;
         raw_sel  = raw_ff.setpoint_raw;
      end else begin
         cal_zero = cfg.fb_cal_zero;
         cal_full = cfg.fb_cal_full;
         raw_sel  = raw_ff.feedback_raw;
      end
      span     = $signed({1'b0, cal_full}) - $signed({1'b0, cal_zero});
      diff     = $signed({1'b0, raw_sel}) - $signed({1'b0, cal_zero});
      num      = $signed({{9{diff[12]}}, diff}) * $signed(22'(DEG_FULL));
      num_mag  = num[21] ? -num : num;
      span_mag = span[12] ? -span : span;
      deg      = sat_angle(div_q, neg_ff);

      err = $signed({3'b0, res_ff.setpoint_deg})
            - $signed({res_ff.feedback_deg[10], res_ff.feedback_deg});

      // Divide the PID sum magnitude by the gain scale
      acc_mag  = acc_ff[21] ? 22'(-acc_ff) : 22'(acc_ff);
      quo_prod = 44'(acc_mag) * 44'(GAIN_RECIP);

      // Rate limit and clamp of the scaled sum
      ctl_q = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      step  = $signed({ctl_q[14], ctl_q}) - 16'(last_out_ff);
      lim   = $signed({ctl_q[14], ctl_q});
      if (step > 16'sd100) begin
         lim = 16'(last_out_ff) + 16'(STEP_LIMIT);
      end else if (step < -16'sd100) begin
         lim = 16'(last_out_ff) - 16'(STEP_LIMIT);
      end
      if (lim > 16'(DUTY_FULL)) begin
         lim = 16'(DUTY_FULL);
      end
      if (lim < -16'(DUTY_FULL)) begin
         lim = -16'(DUTY_FULL);
      end

      // Direction, anti-windup and minimum duty
      if (ctl_ff > 8'(SIGN_HYST)) begin
         sign = DIR_POS;
      end else if (ctl_ff < -8'sd10) begin
         sign = DIR_NEG;
      end else begin
         sign = DIR_NONE;
      end
      wind_hold = (ctl_ff >= 8'(DUTY_FULL) && err > 12'sd0)
                  || (ctl_ff <= -8'sd120 && err < 12'sd0);
      integ_sum = 13'(integ_ff) + 13'(err);
      if (integ_sum > 13'(INTEG_LIMIT)) begin
         integ_sum = 13'(INTEG_LIMIT);
      end
      if (integ_sum < -13'(INTEG_LIMIT)) begin
         integ_sum = -13'(INTEG_LIMIT);
      end
      mag = ctl_ff[7] ? 8'(-ctl_ff) : 8'(ctl_ff);
      if (mag != 8'd0 && mag < 8'(DUTY_MIN)) begin
         mag = 8'(DUTY_MIN);
      end

      // Drive in millivolts from the registered duty
      mv_num  = 20'(mag_ff) * 20'(SUPPLY_MV);
      mv_prod = 41'(mv_num) * 41'(MV_RECIP);

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               raw_in   = q_item;
               state_in = S_SP;
            end
         end
         S_SP, S_FB: begin
            if (span == 13'sd0) begin
               if (state_ff == S_SP) begin
                  res_in.setpoint_deg = 9'(SP_LOW);
                  state_in = S_FB;
               end else begin
                  res_in.feedback_deg = '0;
                  state_in = S_ERR;
               end
            end else begin
               div_start    = 1'b1;
               div_dividend = {1'b0, num_mag};
               div_divisor  = span_mag;
               neg_in       = num[21] ^ span[12];
               state_in     = (state_ff == S_SP) ? S_SP_WAIT : S_FB_WAIT;
            end
         end
         S_SP_WAIT: begin
            if (div_done) begin
               if (deg < 11'(SP_LOW)) begin
                  res_in.setpoint_deg = 9'(SP_LOW);
               end else if (deg > 11'(SP_HIGH)) begin
                  res_in.setpoint_deg = 9'(SP_HIGH);
               end else begin
                  res_in.setpoint_deg = deg[8:0];
               end
               state_in = S_FB;
            end
         end
         S_FB_WAIT: begin
            if (div_done) begin
               res_in.feedback_deg = deg;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            res_in.angle_error = err;
            last_fb_in         = res_ff.feedback_deg;
            if (err > -12'(DEADBAND) && err < 12'(DEADBAND)) begin
               // Inside the deadband: stop the drive and clear the integral
               integ_in           = '0;
               rev_pend_in        = 1'b0;
               res_in.duty        = '0;
               res_in.dir_write   = DIR_NONE;
               res_in.control_out = '0;
               res_in.drive_mv    = '0;
               state_in           = S_OUT;
            end else begin
               deriv_in = 12'(last_fb_ff) - 12'(res_ff.feedback_deg);
               acc_in   = 22'($signed({1'b0, cfg.prop_gain}) * err);
               state_in = S_MUL_I;
            end
         end
         S_MUL_I: begin
            acc_in   = acc_ff + 22'($signed({1'b0, cfg.integ_gain}) * integ_ff);
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            acc_in   = acc_ff + 22'($signed({1'b0, cfg.deriv_gain}) * deriv_ff);
            state_in = S_QUO;
         end
         S_QUO: begin
            quo_in   = quo_prod[GAIN_SHIFT+13:GAIN_SHIFT];
            neg_in   = acc_ff[21];
            state_in = S_QUO_WAIT;
         end
         S_QUO_WAIT: begin
            ctl_in   = lim[7:0];
            state_in = S_CTRL;
         end
         S_CTRL: begin
            if (!wind_hold) begin
               integ_in = integ_sum[10:0];
            end
            last_out_in        = ctl_ff;
            res_in.dir_write   = DIR_NONE;
            res_in.duty        = '0;
            res_in.control_out = '0;
            res_in.drive_mv    = '0;
            if (!rev_pend_ff && sign != DIR_NONE && last_dir_ff != DIR_NONE
                && sign != last_dir_ff) begin
               // Reversal: insert one idle tick
               rev_pend_in = 1'b1;
               pend_fwd_in = (sign == DIR_POS);
               state_in    = S_OUT;
            end else begin
               if (rev_pend_ff) begin
                  res_in.dir_write = pend_fwd_ff ? DIR_POS : DIR_NEG;
                  rev_pend_in      = 1'b0;
               end
               if (sign != DIR_NONE) begin
                  last_dir_in = sign;
               end
               res_in.duty        = mag[6:0];
               res_in.control_out = ctl_ff;
               mag_in             = mag;
               if (mag == 8'd0) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_MV_WAIT;
               end
            end
         end
         S_MV_WAIT: begin
            res_in.drive_mv = mv_prod[MV_SHIFT+12:MV_SHIFT];
            state_in        = S_OUT;
         end
         S_OUT: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         integ_ff    <= '0;
         last_fb_ff  <= '0;
         last_out_ff <= '0;
         last_dir_ff <= DIR_NONE;
         rev_pend_ff <= 1'b0;
         pend_fwd_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         integ_ff    <= integ_in;
         last_fb_ff  <= last_fb_in;
         last_out_ff <= last_out_in;
         last_dir_ff <= last_dir_in;
         rev_pend_ff <= rev_pend_in;
         pend_fwd_ff <= pend_fwd_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      deriv_ff <= deriv_in;
      ctl_ff   <= ctl_in;
      mag_ff   <= mag_in;
      quo_ff   <= quo_in;
      res_ff   <= res_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/pid_position_controller_unit.sv
// ----------------------------------------------------------------------------
// pid_position_controller_unit
// PID position controller with anti-windup and reversal idle tick.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_*     in         one control tick: setpoint and feedback ADC samples
//  rsp_*     out        one result per tick: duty, direction, angles, drive
//  csr_*     in/out     gains and calibration points
//
//  Each angle whose two calibration points differ passes through the shared
//  one-bit-per-cycle divider, and a tick outside the deadband adds the PID sum,
//  limits and drive steps; the result then waits on rsp_tready.
//  Reset is synchronous and clears the controller state and the queue.
//  A two-entry queue takes new items while a result waits on rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_controller_unit (
   input  wire         clock,
   input  wire         reset,
   // setpoint_raw [11:0], feedback_raw [23:12]
   input  wire  [23:0] req_tdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   // duty [6:0], dir_write [8:7], setpoint_deg [17:9], feedback_deg [28:18],
   // angle_error [40:29], control_out [48:41], drive_mv [61:49], zero [63:62]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pidpc_pkg::*;

   pidpc_cfg_type    cfg_ff, cfg_in;
   pidpc_item_type   in_item, q_item;
   pidpc_result_type res;
   logic             q_valid, q_pop;
   logic [2:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_PROP_GAIN:   cfg_in.prop_gain   = csr_pwdata[7:0];
            REG_INTEG_GAIN:  cfg_in.integ_gain  = csr_pwdata[6:0];
            REG_DERIV_GAIN:  cfg_in.deriv_gain  = csr_pwdata[6:0];
            REG_SP_CAL_ZERO: cfg_in.sp_cal_zero = csr_pwdata[CAL_W-1:0];
            REG_SP_CAL_FULL: cfg_in.sp_cal_full = csr_pwdata[CAL_W-1:0];
            REG_FB_CAL_ZERO: cfg_in.fb_cal_zero = csr_pwdata[CAL_W-1:0];
            REG_FB_CAL_FULL: cfg_in.fb_cal_full = csr_pwdata[CAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= 8'd30;
         cfg_ff.integ_gain  <= 7'd10;
         cfg_ff.deriv_gain  <= 7'd0;
         cfg_ff.sp_cal_zero <= CAL_W'(4061);
         cfg_ff.sp_cal_full <= '0;
         cfg_ff.fb_cal_zero <= CAL_W'(4057);
         cfg_ff.fb_cal_full <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      case (reg_idx)
         REG_PROP_GAIN:   csr_prdata = 32'(cfg_ff.prop_gain);
         REG_INTEG_GAIN:  csr_prdata = 32'(cfg_ff.integ_gain);
         REG_DERIV_GAIN:  csr_prdata = 32'(cfg_ff.deriv_gain);
         REG_SP_CAL_ZERO: csr_prdata = 32'(cfg_ff.sp_cal_zero);
         REG_SP_CAL_FULL: csr_prdata = 32'(cfg_ff.sp_cal_full);
         REG_FB_CAL_ZERO: csr_prdata = 32'(cfg_ff.fb_cal_zero);
         REG_FB_CAL_FULL: csr_prdata = 32'(cfg_ff.fb_cal_full);
         default:         csr_prdata = '0;
      endcase
   end

   assign in_item.setpoint_raw = req_tdata[11:0];
   assign in_item.feedback_raw = req_tdata[23:12];

   pidpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   pidpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (res)
   );

   // Pack the result item
   assign rsp_tdata = {2'b00, res.drive_mv, res.control_out, res.angle_error,
                       res.feedback_deg, res.setpoint_deg, res.dir_write, res.duty};

endmodule

`default_nettype wire
